// ===== rtl/core/sppc_pkg.sv =====
package sppc_pkg;

    localparam int SampleW   = 10;
    localparam int AngleW    = 10;
    localparam int PulseW    = 12;
    localparam int NearW     = 8;
    localparam int CpdW      = 16;
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 16;

    // product of signed angle and zero-extended Q8.8 gain
    localparam int ProdW  = AngleW + CpdW + 1;
    // sample minus target, signed
    localparam int DiffW  = 20;
    // magnitude fed to the divide-by-5
    localparam int MagW   = 18;
    // reciprocal of 5, exact for magnitudes below 2^21 / 3
    localparam int RecipW = 19;
    localparam int RecipShift = 21;
    localparam logic [RecipW-1:0] Recip5 = 19'd419431;
    localparam int QuotW  = 15;
    // signed pulse width before clamping
    localparam int PwmW   = 17;

    typedef logic [CfgIndexW-1:0] cfg_index_t;

    localparam cfg_index_t CfgNearRange     = 3'd0;
    localparam cfg_index_t CfgCountsPerDeg  = 3'd1;
    localparam cfg_index_t CfgCenterPulse   = 3'd2;
    localparam cfg_index_t CfgMinSpeedAbove = 3'd3;
    localparam cfg_index_t CfgMinSpeedBelow = 3'd4;
    localparam cfg_index_t CfgMaxForward    = 3'd5;
    localparam cfg_index_t CfgMaxBackward   = 3'd6;

    localparam logic [NearW-1:0]  RstNearRange     = 8'd10;
    localparam logic [CpdW-1:0]   RstCountsPerDeg  = 16'd873;
    localparam logic [PulseW-1:0] RstCenterPulse   = 12'd1500;
    localparam logic [PulseW-1:0] RstMinSpeedAbove = 12'd1550;
    localparam logic [PulseW-1:0] RstMinSpeedBelow = 12'd1450;
    localparam logic [PulseW-1:0] RstMaxForward    = 12'd1700;
    localparam logic [PulseW-1:0] RstMaxBackward   = 12'd1300;

    localparam logic [SampleW-1:0] SafeHigh = 10'd900;
    localparam logic [SampleW-1:0] SafeLow  = 10'd200;

    localparam logic signed [PwmW-1:0] PwmMid    = 17'sd1500;
    localparam logic signed [PwmW-1:0] DeadUpper = 17'sd1510;
    localparam logic signed [PwmW-1:0] DeadLower = 17'sd1490;

    localparam logic [SampleW:0] MoveLimit = 11'd5;

endpackage

// ===== rtl/core/servo_position_p_controller.sv =====
// Proportional servo position controller with dead band.
//
// Input channel: in_valid / in_stall carry one beat of pot_sample (10-bit
// ADC counts) and target_angle (signed whole degrees). Output channel:
// out_valid / out_stall carry one beat per input beat: pulse_width,
// pulse_write, arrived, safety_stop. Results leave in input order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; the
// port always takes a write. Indexes beyond the register list are dropped.
// Write registers only while no beat is in flight.
//
// A beat passes from the input register through each stage in turn to
// the result register. Throughput: one beat per cycle while out_stall is
// low, through a six-register pipeline (input, gain product, difference,
// magnitude, divide-by-5, result); the last-position register is read and
// written in the final stage only, so consecutive beats need no spacing.
// When the receiver stalls, each stage holds and fills up behind the
// output register; in_stall rises only once every stage is occupied.
// Reset empties the pipeline, clears the last position and loads the
// register defaults.
module servo_position_p_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sppc_pkg::SampleW-1:0]  pot_sample,
    input  logic [sppc_pkg::AngleW-1:0]   target_angle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sppc_pkg::PulseW-1:0]   pulse_width,
    output logic                          pulse_write,
    output logic                          arrived,
    output logic                          safety_stop,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sppc_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [sppc_pkg::CfgDataW-1:0] cfg_data
);
    import sppc_pkg::*;

    logic [NearW-1:0]  near_range_reg;
    logic [CpdW-1:0]   cpd_reg;
    logic [PulseW-1:0] center_pulse_reg;
    logic [PulseW-1:0] min_above_reg;
    logic [PulseW-1:0] min_below_reg;
    logic [PulseW-1:0] max_fwd_reg;
    logic [PulseW-1:0] max_bwd_reg;
    logic [SampleW-1:0] last_pos_reg;

    logic [5:0] valid_reg;
    logic [5:0] ready;

    logic [SampleW-1:0] s0_sample_reg;
    logic [AngleW-1:0]  s0_angle_reg;

    logic [SampleW-1:0]     s1_sample_reg;
    logic                   s1_safe_reg;
    logic signed [ProdW-1:0] s1_prod_reg;

    logic [SampleW-1:0]     s2_sample_reg;
    logic                   s2_safe_reg;
    logic signed [DiffW-1:0] s2_diff_reg;

    logic [SampleW-1:0] s3_sample_reg;
    logic               s3_safe_reg;
    logic               s3_near_reg;
    logic               s3_neg_reg;
    logic [MagW-1:0]    s3_mag_reg;

    logic [SampleW-1:0] s4_sample_reg;
    logic               s4_safe_reg;
    logic               s4_near_reg;
    logic               s4_neg_reg;
    logic [QuotW-1:0]   s4_quot_reg;

    logic [PulseW-1:0] pulse_width_reg;
    logic              pulse_write_reg;
    logic              arrived_reg;
    logic              safety_stop_reg;

    logic signed [ProdW-1:0]  s1_prod_next;
    logic                     s1_safe_next;
    logic                     s2_round;
    logic signed [DiffW-1:0]  s2_diff_next;
    logic [DiffW-1:0]         s3_abs;
    logic [DiffW-1:0]         s3_mag_wide;
    logic [MagW+RecipW-1:0]   s4_prod;
    logic [SampleW:0]         move_diff;
    logic [SampleW:0]         move_abs;
    logic                     still;
    logic signed [PwmW-1:0]   pwm_raw;
    logic signed [PwmW-1:0]   pwm_dz;
    logic signed [PwmW-1:0]   pwm_next;
    logic signed [PwmW-1:0]   min_above_s;
    logic signed [PwmW-1:0]   min_below_s;
    logic signed [PwmW-1:0]   max_fwd_s;
    logic signed [PwmW-1:0]   max_bwd_s;
    logic                     final_load;

    // handshake chain: a stage loads when empty or when its successor loads
    assign ready[5] = !valid_reg[5] || !out_stall;
    assign ready[4] = !valid_reg[4] || ready[5];
    assign ready[3] = !valid_reg[3] || ready[4];
    assign ready[2] = !valid_reg[2] || ready[3];
    assign ready[1] = !valid_reg[1] || ready[2];
    assign ready[0] = !valid_reg[0] || ready[1];

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[5];
    assign cfg_ready = 1'b1;

    assign pulse_width = pulse_width_reg;
    assign pulse_write = pulse_write_reg;
    assign arrived     = arrived_reg;
    assign safety_stop = safety_stop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_range_reg   <= RstNearRange;
            cpd_reg          <= RstCountsPerDeg;
            center_pulse_reg <= RstCenterPulse;
            min_above_reg    <= RstMinSpeedAbove;
            min_below_reg    <= RstMinSpeedBelow;
            max_fwd_reg      <= RstMaxForward;
            max_bwd_reg      <= RstMaxBackward;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CfgNearRange:     near_range_reg   <= cfg_data[NearW-1:0];
                CfgCountsPerDeg:  cpd_reg          <= cfg_data[CpdW-1:0];
                CfgCenterPulse:   center_pulse_reg <= cfg_data[PulseW-1:0];
                CfgMinSpeedAbove: min_above_reg    <= cfg_data[PulseW-1:0];
                CfgMinSpeedBelow: min_below_reg    <= cfg_data[PulseW-1:0];
                CfgMaxForward:    max_fwd_reg      <= cfg_data[PulseW-1:0];
                CfgMaxBackward:   max_bwd_reg      <= cfg_data[PulseW-1:0];
                default:          ;
            endcase
        end
    end

    // stage 1: gain product and range check
    assign s1_prod_next = $signed(s0_angle_reg) * $signed({1'b0, cpd_reg});
    assign s1_safe_next = (s0_sample_reg > SafeHigh) || (s0_sample_reg < SafeLow);

    // stage 2: target truncated toward zero, then sample minus target
    assign s2_round = s1_prod_reg[ProdW-1] && (|s1_prod_reg[7:0]);
    assign s2_diff_next = $signed({{(DiffW-SampleW){1'b0}}, s1_sample_reg})
                        - $signed({s1_prod_reg[ProdW-1], s1_prod_reg[ProdW-1:8]})
                        - $signed({{(DiffW-1){1'b0}}, s2_round});

    // stage 3: magnitude; floor(d/5) = -floor((-d+4)/5) for negative d
    assign s3_abs      = s2_diff_reg[DiffW-1] ? (~s2_diff_reg + 1'b1) : s2_diff_reg;
    assign s3_mag_wide = s2_diff_reg[DiffW-1] ? (s3_abs + 20'd4) : s3_abs;

    // stage 4: divide by 5 through the reciprocal
    assign s4_prod = {{RecipW{1'b0}}, s3_mag_reg} * {{MagW{1'b0}}, Recip5};

    // stage 5: motion check, dead zone, clamp
    assign move_diff = {1'b0, last_pos_reg} - {1'b0, s4_sample_reg};
    assign move_abs  = move_diff[SampleW] ? (~move_diff + 1'b1) : move_diff;
    assign still     = move_abs <= MoveLimit;

    assign min_above_s = $signed({{(PwmW-PulseW){1'b0}}, min_above_reg});
    assign min_below_s = $signed({{(PwmW-PulseW){1'b0}}, min_below_reg});
    assign max_fwd_s   = $signed({{(PwmW-PulseW){1'b0}}, max_fwd_reg});
    assign max_bwd_s   = $signed({{(PwmW-PulseW){1'b0}}, max_bwd_reg});

    assign pwm_raw = s4_neg_reg
                   ? PwmMid - $signed({{(PwmW-QuotW){1'b0}}, s4_quot_reg})
                   : PwmMid + $signed({{(PwmW-QuotW){1'b0}}, s4_quot_reg});

    always_comb
    begin
        priority if (pwm_raw < min_above_s && pwm_raw > DeadUpper)
            pwm_dz = min_above_s;
        else if (pwm_raw > min_below_s && pwm_raw < DeadLower)
            pwm_dz = min_below_s;
        else
            pwm_dz = pwm_raw;

        priority if (pwm_dz > max_fwd_s)
            pwm_next = max_fwd_s;
        else if (pwm_dz < max_bwd_s)
            pwm_next = max_bwd_s;
        else
            pwm_next = pwm_dz;
    end

    assign final_load = valid_reg[4] && ready[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            last_pos_reg <= '0;
        end
        else
        begin
            if (ready[0]) valid_reg[0] <= in_valid;
            if (ready[1]) valid_reg[1] <= valid_reg[0];
            if (ready[2]) valid_reg[2] <= valid_reg[1];
            if (ready[3]) valid_reg[3] <= valid_reg[2];
            if (ready[4]) valid_reg[4] <= valid_reg[3];
            if (ready[5]) valid_reg[5] <= valid_reg[4];
            if (final_load && (s4_safe_reg || !(s4_near_reg && still)))
                last_pos_reg <= s4_sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            s0_sample_reg <= pot_sample;
            s0_angle_reg  <= target_angle;
        end
        if (ready[1] && valid_reg[0])
        begin
            s1_sample_reg <= s0_sample_reg;
            s1_safe_reg   <= s1_safe_next;
            s1_prod_reg   <= s1_prod_next;
        end
        if (ready[2] && valid_reg[1])
        begin
            s2_sample_reg <= s1_sample_reg;
            s2_safe_reg   <= s1_safe_reg;
            s2_diff_reg   <= s2_diff_next;
        end
        if (ready[3] && valid_reg[2])
        begin
            s3_sample_reg <= s2_sample_reg;
            s3_safe_reg   <= s2_safe_reg;
            s3_near_reg   <= s3_abs <= {{(DiffW-NearW){1'b0}}, near_range_reg};
            s3_neg_reg    <= s2_diff_reg[DiffW-1];
            s3_mag_reg    <= s3_mag_wide[MagW-1:0];
        end
        if (ready[4] && valid_reg[3])
        begin
            s4_sample_reg <= s3_sample_reg;
            s4_safe_reg   <= s3_safe_reg;
            s4_near_reg   <= s3_near_reg;
            s4_neg_reg    <= s3_neg_reg;
            s4_quot_reg   <= s4_prod[RecipShift+QuotW-1:RecipShift];
        end
        if (final_load)
        begin
            priority if (s4_safe_reg)
            begin
                pulse_width_reg <= center_pulse_reg;
                pulse_write_reg <= 1'b1;
                arrived_reg     <= 1'b1;
                safety_stop_reg <= 1'b1;
            end
            else if (s4_near_reg && still)
            begin
                pulse_width_reg <= '0;
                pulse_write_reg <= 1'b0;
                arrived_reg     <= 1'b1;
                safety_stop_reg <= 1'b0;
            end
            else
            begin
                pulse_width_reg <= pwm_next[PulseW-1:0];
                pulse_write_reg <= 1'b1;
                arrived_reg     <= 1'b0;
                safety_stop_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== tb/sv/servo_pulse_checker.sv =====
`timescale 1ns / 100ps

module servo_pulse_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [sppc_pkg::SampleW-1:0]   pot_sample,
    input  logic [sppc_pkg::AngleW-1:0]    target_angle,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [sppc_pkg::PulseW-1:0]    pulse_width,
    input  logic                           pulse_write,
    input  logic                           arrived,
    input  logic                           safety_stop,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [sppc_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [sppc_pkg::CfgDataW-1:0]  cfg_data,
    output int                             fault_count,
    output int                             results_owed
);
    import sppc_pkg::*;

    localparam int PropDivisor = 5;
    localparam int ReportLimit = 10;

    typedef struct packed {
        logic [PulseW-1:0] width;
        logic              write;
        logic              at_target;
        logic              stopped;
    } servo_cmd_t;

    logic [NearW-1:0]   near_range;
    logic [CpdW-1:0]    gain_q8;
    logic [PulseW-1:0]  centre_width;
    logic [PulseW-1:0]  floor_above;
    logic [PulseW-1:0]  ceil_below;
    logic [PulseW-1:0]  limit_fwd;
    logic [PulseW-1:0]  limit_back;
    logic [SampleW-1:0] last_pos;
    servo_cmd_t         owed_cmds[$];
    int                 err_cnt;

    function automatic servo_cmd_t steer(input logic [SampleW-1:0] smp_bits,
                                         input logic [AngleW-1:0]  ang_bits);
        int         smp;
        int         ang;
        int         tgt;
        int         dif;
        int         mov;
        int         quo;
        int         pwm;
        servo_cmd_t cmd;
        smp = int'(smp_bits);
        ang = int'($signed(ang_bits));
        if (smp > int'(SafeHigh) || smp < int'(SafeLow))
        begin
            last_pos = smp_bits;
            cmd = '{centre_width, 1'b1, 1'b1, 1'b1};
            return cmd;
        end
        tgt = (ang * int'(gain_q8)) / 256;
        dif = smp - tgt;
        mov = int'(last_pos) - smp;
        if ((dif < 0 ? -dif : dif) <= int'(near_range) &&
            (mov < 0 ? -mov : mov) <= int'(MoveLimit))
        begin
            cmd = '{'0, 1'b0, 1'b1, 1'b0};
            return cmd;
        end
        last_pos = smp_bits;
        // proportional term rounds towards minus infinity
        quo = dif / PropDivisor;
        if (dif % PropDivisor != 0 && dif < 0)
            quo -= 1;
        pwm = int'(PwmMid) + quo;
        if (pwm < int'(floor_above) && pwm > int'(DeadUpper))
            pwm = int'(floor_above);
        else if (pwm > int'(ceil_below) && pwm < int'(DeadLower))
            pwm = int'(ceil_below);
        if (pwm > int'(limit_fwd))
            pwm = int'(limit_fwd);
        else if (pwm < int'(limit_back))
            pwm = int'(limit_back);
        cmd = '{pwm[PulseW-1:0], 1'b1, 1'b0, 1'b0};
        return cmd;
    endfunction

    always @(posedge clk)
    begin
        servo_cmd_t want;
        servo_cmd_t seen;
        if (!rst_n)
        begin
            near_range   = RstNearRange;
            gain_q8      = RstCountsPerDeg;
            centre_width = RstCenterPulse;
            floor_above  = RstMinSpeedAbove;
            ceil_below   = RstMinSpeedBelow;
            limit_fwd    = RstMaxForward;
            limit_back   = RstMaxBackward;
            last_pos     = '0;
            owed_cmds.delete();
            err_cnt      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CfgNearRange:     near_range   = cfg_data[NearW-1:0];
                    CfgCountsPerDeg:  gain_q8      = cfg_data[CpdW-1:0];
                    CfgCenterPulse:   centre_width = cfg_data[PulseW-1:0];
                    CfgMinSpeedAbove: floor_above  = cfg_data[PulseW-1:0];
                    CfgMinSpeedBelow: ceil_below   = cfg_data[PulseW-1:0];
                    CfgMaxForward:    limit_fwd    = cfg_data[PulseW-1:0];
                    CfgMaxBackward:   limit_back   = cfg_data[PulseW-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen = '{pulse_width, pulse_write, arrived, safety_stop};
                if (owed_cmds.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= ReportLimit)
                        $display({"%0t unexpected output beat: ",
                                  "width=%0d write=%0b arrived=%0b stop=%0b"},
                                 $time, seen.width, seen.write, seen.at_target,
                                 seen.stopped);
                end
                else
                begin
                    want = owed_cmds.pop_front();
                    if (seen !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= ReportLimit)
                            $display({"%0t mismatch: expected width=%0d write=%0b ",
                                      "arrived=%0b stop=%0b, got width=%0d ",
                                      "write=%0b arrived=%0b stop=%0b"},
                                     $time, want.width, want.write, want.at_target,
                                     want.stopped, seen.width, seen.write,
                                     seen.at_target, seen.stopped);
                    end
                end
            end
            if (in_valid && !in_stall)
                owed_cmds.push_back(steer(pot_sample, target_angle));
        end
        fault_count  <= err_cnt;
        results_owed <= owed_cmds.size();
    end

endmodule

// ===== tb/sv/tb_servo_position_p_controller.sv =====
`timescale 1ns / 100ps

module tb_servo_position_p_controller;
    import sppc_pkg::*;

    localparam cfg_index_t CfgUnused = 3'd7;
    localparam int QuietLimit  = 1000;
    localparam int DrainCycles = 8;
    localparam int PhaseBeats  = 95;
    localparam int NumPhases   = 8;
    localparam int SampleMax   = (1 << SampleW) - 1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [SampleW-1:0]   pot_sample;
    logic [AngleW-1:0]    target_angle;
    logic                 out_valid;
    logic                 out_stall;
    logic [PulseW-1:0]    pulse_width;
    logic                 pulse_write;
    logic                 arrived;
    logic                 safety_stop;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;
    int                   fault_count;
    int                   results_owed;
    int                   quiet_cycles;
    bit                   idle_on;
    logic [NearW-1:0]     near_now;
    logic [CpdW-1:0]      gain_now;

    always #6 clk = ~clk;

    servo_position_p_controller uut (.*);

    servo_pulse_checker checker_i (.*);

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver back-pressure in bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic int clip(input int v);
        return v < 0 ? 0 : (v > SampleMax ? SampleMax : v);
    endfunction

    function automatic int aim(input int ang);
        return (ang * int'(gain_now)) / 256;
    endfunction

    task automatic send_beat(input int smp, input int ang);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        pot_sample   <= smp[SampleW-1:0];
        target_angle <= ang[AngleW-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input int val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CfgDataW-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure(input int near, input int gain, input int centre,
                               input int above, input int below, input int fwd,
                               input int back, input bit poke);
        write_cfg(CfgNearRange, near, 1'b0);
        write_cfg(CfgCountsPerDeg, gain, 1'b0);
        write_cfg(CfgCenterPulse, centre, 1'b0);
        write_cfg(CfgMinSpeedAbove, above, 1'b0);
        write_cfg(CfgMinSpeedBelow, below, 1'b0);
        write_cfg(CfgMaxForward, fwd, 1'b0);
        write_cfg(CfgMaxBackward, back, !poke);
        if (poke)
            write_cfg(CfgUnused, $urandom_range(0, 65535), 1'b1);
        near_now = near[NearW-1:0];
        gain_now = gain[CpdW-1:0];
    endtask

    task automatic directed_beats();
        send_beat(0, 0);
        send_beat(SampleMax, 511);
        send_beat(199, 100);
        send_beat(200, 100);
        send_beat(900, 100);
        send_beat(901, 100);
        send_beat(500, -512);
        send_beat(500, -1);
        // target 341 at the reset gain
        send_beat(341, 100);
        send_beat(341, 100);
        send_beat(351, 100);
        send_beat(351, 100);
        send_beat(352, 100);
        // dead band edges
        send_beat(396, 100);
        send_beat(391, 100);
        send_beat(286, 100);
        send_beat(291, 100);
        send_beat(338, 100);
        // clamps
        send_beat(900, -360);
        send_beat(200, 360);
        send_beat(205, 360);
        send_beat(600, 511);
    endtask

    task automatic random_run(input int beats);
        int sent;
        int kind;
        int ang;
        int tgt;
        int smp;
        int r;
        sent = 0;
        while (sent < beats)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // approach a target, then hover round it
                tgt = $urandom_range(210, 890);
                ang = (gain_now == 0) ? int'($urandom_range(0, 1023)) - 512
                                      : tgt * 256 / int'(gain_now);
                if (ang > 511)
                    ang = 511;
                tgt = aim(ang);
                smp = $urandom_range(SafeLow, SafeHigh);
                repeat ($urandom_range(1, 5))
                begin
                    smp = clip(smp + (tgt - smp) / 2);
                    send_beat(smp, ang);
                    sent++;
                end
                r = (near_now > 3) ? 3 : int'(near_now);
                if ($urandom_range(0, 3) == 0)
                    r = int'(near_now) + 1;
                repeat ($urandom_range(1, 5))
                begin
                    smp = tgt + int'($urandom_range(0, 2 * r)) - r;
                    if ($urandom_range(0, 15) == 0)
                        smp = $urandom_range(0, SampleMax);
                    send_beat(clip(smp), ang);
                    sent++;
                end
            end
            else if (kind <= 7)
            begin
                send_beat($urandom_range(0, SampleMax), int'($urandom_range(0, 1023)) - 512);
                sent++;
            end
            else if (kind == 8)
            begin
                smp = $urandom_range(0, 1) ? $urandom_range(0, SafeLow - 1)
                                           : $urandom_range(SafeHigh + 1, SampleMax);
                send_beat(smp, int'($urandom_range(0, 1023)) - 512);
                sent++;
            end
            else
            begin
                // near-window and movement thresholds
                ang = $urandom_range(0, 300);
                tgt = aim(ang);
                smp = tgt + ($urandom_range(0, 1) ? 1 : -1) *
                      (int'(near_now) + int'($urandom_range(0, 1)));
                send_beat(clip(smp), ang);
                smp = smp + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(5, 6));
                send_beat(clip(smp), ang);
                sent += 2;
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        pot_sample   <= '0;
        target_angle <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CfgNearRange;
        cfg_data     <= '0;
        idle_on      = 1'b1;
        near_now     = RstNearRange;
        gain_now     = RstCountsPerDeg;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_beats();
        random_run(PhaseBeats);
        for (int p = 0; p < NumPhases; p++)
        begin
            settle();
            idle_on = (p % 3 != 2) && (p != NumPhases - 1);
            case (p)
                0: reconfigure(0, 0, 0, 0, 0, 0, 0, 1'b1);
                1: reconfigure(255, 65535, 4095, 4095, 4095, 4095, 4095, 1'b0);
                // inverted limits
                2: reconfigure($urandom_range(0, 30), $urandom_range(300, 1500),
                               $urandom_range(0, 4095), $urandom_range(1511, 1800),
                               $urandom_range(1200, 1489), 1400, 1600, 1'b0);
                4: reconfigure($urandom_range(0, 255), $urandom_range(0, 65535),
                               $urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), 1'b1);
                NumPhases - 1:
                   reconfigure(RstNearRange, RstCountsPerDeg, RstCenterPulse,
                               RstMinSpeedAbove, RstMinSpeedBelow, RstMaxForward,
                               RstMaxBackward, 1'b0);
                default:
                   reconfigure($urandom_range(0, 40), $urandom_range(400, 1200),
                               $urandom_range(1000, 2000), $urandom_range(1511, 1700),
                               $urandom_range(1300, 1489), $urandom_range(1600, 2500),
                               $urandom_range(500, 1400), 1'b0);
            endcase
            random_run(PhaseBeats);
        end
        settle();
        repeat (DrainCycles) @(posedge clk);
        if (fault_count == 0 && results_owed == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
